/* rtl/grid_cell_point_accumulator_unit_assert.svh */
// assertion macros for the grid cell accumulator rtl
// depends on nothing; included by modules that assert
`ifndef GRID_CELL_POINT_ACCUMULATOR_UNIT_ASSERT_SVH
`define GRID_CELL_POINT_ACCUMULATOR_UNIT_ASSERT_SVH
// property that holds at every clock edge outside reset
`define GCPA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define GCPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/gcpa_pkg.sv */
// shared types and constants of the grid cell point accumulator
// no dependencies
`timescale 1ns / 1ps
package gcpa_pkg;
  localparam int unsigned RowsLog2Def = 8;
  localparam int unsigned ColsLog2Def = 8;
  localparam int unsigned FifoDepth   = 2;

  typedef enum logic [1:0] {
    ActAdd   = 2'd0,
    ActSweep = 2'd1,
    ActClear = 2'd2,
    ActNone  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    RegOriginValid = 3'd0,
    RegOriginX     = 3'd1,
    RegOriginY     = 3'd2,
    RegShiftX      = 3'd3,
    RegShiftY      = 3'd4,
    RegCellSize    = 3'd5,
    RegIgnoreRad   = 3'd6
  } reg_e;

  // classified item from the front to the back
  typedef struct packed {
    action_e     act;
    logic        hit;      // cell inside grid and outside ignore radius
    logic        selected;
    logic [19:0] cidx;     // wide enough for the largest grid
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] zq;
  } job_t;

  typedef enum logic [3:0] {
    BkIdle, BkClear, BkRead, BkMul, BkDivM, BkVar, BkDivV, BkSqrt, BkWrite, BkOut
  } bk_state_e;
endpackage

/* rtl/grid_cell_point_accumulator_unit.sv */
// top level of the grid cell point accumulator
// depends on gcpa_pkg, gcpa_front, gcpa_queue, gcpa_back
`timescale 1ns / 1ps
// usage:
// items enter on a queue-like port: an item transfers when push_i is high and
// full_o low. results leave the same way: a result transfers when pop_i is high
// and empty_o low; cell_index_o and in_map_o hold the oldest result.
// only action 0 (add point) gives a result; end of sweep and clear give none.
// configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_data_i), to
// be used only while the block is idle.
// steps: the front bins a point with an iterative divide; the back runs a
// selected point that hits the grid through a mean divide, a variance divide
// and a root (the last two skipped for a cell's first point), and only reads
// and reports any other added point. a clear writes one cell a cycle over all
// 2^(rows_log2+cols_log2) cells; after reset it runs before the first point.
// a two-entry queue lets the front bin the next point while the back works;
// if the receiver stalls the result register holds and the back waits.
module grid_cell_point_accumulator_unit import gcpa_pkg::*; #(
  parameter int unsigned RowsLog2 = RowsLog2Def,
  parameter int unsigned ColsLog2 = ColsLog2Def
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        push_i,
  output logic        full_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic [23:0] point_z_i,
  input  logic        selected_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [15:0] cell_index_o,
  output logic        in_map_o
);
  logic fv, fr, bv, br;
  job_t fj, bj;

  gcpa_front #(.RowsLog2(RowsLog2), .ColsLog2(ColsLog2)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .push_i, .full_o, .action_i, .point_x_i, .point_y_i, .point_z_i, .selected_i,
    .job_valid_o(fv), .job_ready_i(fr), .job_o(fj)
  );

  gcpa_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(fv), .in_ready_o(fr), .in_i(fj),
    .out_valid_o(bv), .out_ready_i(br), .out_o(bj)
  );

  gcpa_back #(.RowsLog2(RowsLog2), .ColsLog2(ColsLog2)) u_back (
    .clk_i, .rst_ni, .job_valid_i(bv), .job_ready_o(br), .job_i(bj),
    .empty_o, .pop_i, .cell_index_o, .in_map_o
  );
endmodule

/* rtl/gcpa_front.sv */
// front: register file, point binning with iterative divide, classification
// depends on gcpa_pkg
`timescale 1ns / 1ps
module gcpa_front import gcpa_pkg::*; #(
  parameter int unsigned RowsLog2 = RowsLog2Def,
  parameter int unsigned ColsLog2 = ColsLog2Def
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        push_i,
  output logic        full_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic [23:0] point_z_i,
  input  logic        selected_i,
  output logic        job_valid_o,
  input  logic        job_ready_i,
  output job_t        job_o
);
  localparam int unsigned Cols = 1 << ColsLog2;
  localparam int unsigned Rows = 1 << RowsLog2;

  logic        org_valid_q;
  logic [31:0] org_x_q, org_y_q;
  logic [8:0]  shx_q, shy_q;
  logic [15:0] csize_q, irad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_valid_q <= 1'b0; org_x_q <= '0; org_y_q <= '0;
      shx_q <= '0; shy_q <= '0; csize_q <= 16'd250; irad_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        RegOriginValid: org_valid_q <= cfg_data_i[0];
        RegOriginX:     org_x_q     <= cfg_data_i;
        RegOriginY:     org_y_q     <= cfg_data_i;
        RegShiftX:      shx_q       <= cfg_data_i[8:0];
        RegShiftY:      shy_q       <= cfg_data_i[8:0];
        RegCellSize:    csize_q     <= cfg_data_i[15:0];
        RegIgnoreRad:   irad_q      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // both axes divided in parallel, one quotient bit per cycle
  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [32:0] nx_q, ny_q;     // magnitudes of offsets
  logic        sx_q, sy_q;
  logic [32:0] rx_q, ry_q;
  logic [32:0] qx_q, qy_q;
  job_t        j_q;
  logic [15:0] dv;
  logic [32:0] rxs, rys;
  logic signed [33:0] offx, offy;
  logic signed [35:0] xc, yc, dr, dc;
  logic [71:0] rsq;
  logic hit_c;
  logic [RowsLog2+ColsLog2-1:0] cell_c;

  assign dv   = (csize_q == 16'd0) ? 16'd1 : csize_q;
  assign offx = 34'(signed'(point_x_i)) - 34'(signed'(org_x_q));
  assign offy = 34'(signed'(point_y_i)) - 34'(signed'(org_y_q));
  assign rxs  = {rx_q[31:0], nx_q[32]};
  assign rys  = {ry_q[31:0], ny_q[32]};

  assign full_o = busy_q | done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        j_q.act      <= action_e'(action_i);
        j_q.selected <= selected_i;
        j_q.px       <= point_x_i;
        j_q.py       <= point_y_i;
        j_q.zq       <= {point_z_i, 8'd0};
        j_q.hit      <= 1'b0;
        j_q.cidx     <= '0;
        nx_q <= offx[33] ? 33'(-offx) : offx[32:0];
        ny_q <= offy[33] ? 33'(-offy) : offy[32:0];
        sx_q <= offx[33]; sy_q <= offy[33];
        rx_q <= '0; ry_q <= '0; qx_q <= '0; qy_q <= '0;
        cnt_q <= 6'd0;
        if (action_e'(action_i) == ActAdd && org_valid_q) busy_q <= 1'b1;
        else done_q <= 1'b1;
      end else if (busy_q) begin
        if (cnt_q == 6'd33) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          j_q.hit  <= hit_c;
          j_q.cidx <= 20'(cell_c);
        end else begin
          cnt_q <= cnt_q + 6'd1;
          nx_q  <= {nx_q[31:0], 1'b0};
          ny_q  <= {ny_q[31:0], 1'b0};
          if (rxs >= 33'(dv)) begin
            rx_q <= rxs - 33'(dv); qx_q <= {qx_q[31:0], 1'b1};
          end else begin
            rx_q <= rxs; qx_q <= {qx_q[31:0], 1'b0};
          end
          if (rys >= 33'(dv)) begin
            ry_q <= rys - 33'(dv); qy_q <= {qy_q[31:0], 1'b1};
          end else begin
            ry_q <= rys; qy_q <= {qy_q[31:0], 1'b0};
          end
        end
      end else if (done_q && job_ready_i) begin
        done_q <= 1'b0;
      end
    end
  end

  // coordinate checks once quotients are ready
  always_comb begin
    xc = (sx_q ? -36'(qx_q) : 36'(qx_q)) + 36'(Cols / 2) + 36'(signed'(shx_q));
    yc = (sy_q ? -36'(qy_q) : 36'(qy_q)) + 36'(Rows / 2) + 36'(signed'(shy_q));
    dc = xc - 36'(Cols / 2);
    dr = yc - 36'(Rows / 2);
    rsq = 72'(signed'(dr[11:0]) * signed'(dr[11:0]))
        + 72'(signed'(dc[11:0]) * signed'(dc[11:0]));
    hit_c = !xc[35] && xc < 36'(Cols) && !yc[35] && yc < 36'(Rows) && rsq >= 72'(irad_q);
    cell_c = {yc[RowsLog2-1:0], xc[ColsLog2-1:0]};
  end

  assign job_valid_o = done_q;
  assign job_o       = j_q;
endmodule

/* rtl/gcpa_queue.sv */
// short queue between front and back
// depends on gcpa_pkg
`timescale 1ns / 1ps
module gcpa_queue import gcpa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  job_t in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output job_t out_o
);
  job_t mem_q [FifoDepth];
  logic wp_q, rp_q;
  logic [1:0] n_q;
  logic wr, rd;
  assign in_ready_o  = n_q != 2'd2;
  assign out_valid_o = n_q != 2'd0;
  assign out_o = mem_q[rp_q];
  assign wr = in_valid_i && in_ready_o;
  assign rd = out_valid_o && out_ready_i;
  always_ff @(posedge clk_i) if (wr) mem_q[wp_q] <= in_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; n_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      n_q <= n_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

/* rtl/gcpa_back.sv */
// back: cell memory, statistics update with iterative divide and root, result register
// depends on gcpa_pkg and the assertion header
`timescale 1ns / 1ps
`include "grid_cell_point_accumulator_unit_assert.svh"
module gcpa_back import gcpa_pkg::*; #(
  parameter int unsigned RowsLog2 = RowsLog2Def,
  parameter int unsigned ColsLog2 = ColsLog2Def
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  job_t        job_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [15:0] cell_index_o,
  output logic        in_map_o
);
  localparam int unsigned Aw = RowsLog2 + ColsLog2;
  localparam int unsigned Cells = 1 << Aw;
  // packed cell: count, id, mean, std, sweep, minx, maxx, miny, maxy
  localparam int unsigned Ew = 16 + 16 + 32 * 7;

  typedef struct packed {
    logic [15:0] cnt;
    logic [15:0] id;
    logic [31:0] mean;
    logic [31:0] sd;
    logic [31:0] swp;
    logic [31:0] minx, maxx, miny, maxy;
  } cell_t;

  logic [Ew-1:0] mem [Cells];
  logic [Ew-1:0] rdat_q;
  logic          mwe;
  logic [Aw-1:0] maddr;
  logic [Ew-1:0] mwdat;
  always_ff @(posedge clk_i) begin
    if (mwe) mem[maddr] <= mwdat;
    rdat_q <= mem[maddr];
  end

  cell_t clr_cell;
  assign clr_cell = '{cnt: '0, id: '0, mean: '0, sd: '0, swp: '0,
                      minx: 32'h7fffffff, maxx: 32'h80000000,
                      miny: 32'h7fffffff, maxy: 32'h80000000};

  bk_state_e st_q, st_d;
  job_t      j_q;
  cell_t     c_q;
  logic [Aw:0]  clr_q;
  logic [16:0]  nid_q;
  logic [31:0]  swc_q;
  logic         ov_q;
  logic [15:0]  oi_q;
  logic         om_q;
  // arithmetic registers
  logic [16:0]  n1_q;
  logic [6:0]   it_q;
  logic [127:0] num_q;   // dividend magnitude, shifted left
  logic [17:0]  rem_q;
  logic [127:0] quo_q;
  logic         nsg_q;
  logic signed [32:0] newm_q;
  logic [63:0]  prod_q, var_q;
  logic [63:0]  sqv_q, sqr_q, sqb_q;
  logic [63:0]  ss_q;
  logic [1:0]   mph_q;

  logic [18:0]  rsh;
  assign rsh = {rem_q, num_q[127]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= BkClear;
    else         st_q <= st_d;
  end

  always_comb begin
    st_d = st_q;
    mwe = 1'b0;
    maddr = j_q.cidx[Aw-1:0];
    mwdat = c_q;
    job_ready_o = 1'b0;
    unique case (st_q)
      BkIdle: begin
        job_ready_o = 1'b1;
        maddr = job_i.cidx[Aw-1:0];
        if (job_valid_i) begin
          priority case (job_i.act)
            ActClear: st_d = BkClear;
            ActAdd:   st_d = BkRead;
            default:  st_d = BkIdle;
          endcase
        end
      end
      BkClear: begin
        maddr = clr_q[Aw-1:0]; mwe = 1'b1; mwdat = clr_cell;
        if (clr_q == (Aw+1)'(Cells - 1)) st_d = BkIdle;
      end
      BkRead: st_d = j_q.hit && j_q.selected ? BkMul : BkOut;
      BkMul:  if (mph_q == 2'd3) st_d = BkDivM;
      BkDivM: if (it_q == 7'd64) st_d = BkVar;
      BkVar:  if (mph_q == 2'd3) st_d = (n1_q == 17'd1) ? BkWrite : BkDivV;
      BkDivV: if (it_q == 7'd127) st_d = BkSqrt;
      BkSqrt: if (it_q == 7'd32) st_d = BkWrite;
      BkWrite: begin mwe = 1'b1; st_d = BkOut; end
      BkOut:  if (!ov_q) st_d = BkIdle;
      default: st_d = BkIdle;
    endcase
  end

  cell_t rc;
  assign rc = cell_t'(rdat_q);
  logic signed [63:0] d1, d2, sm;
  logic signed [63:0] oldm_s;
  logic signed [48:0] mprod;
  logic [31:0] m1, m2;
  logic [127:0] vfull;
  logic [63:0] sqt;

  always_comb begin
    oldm_s = 64'(signed'(c_q.mean));
    d1 = 64'(signed'(j_q.zq)) - oldm_s;
    d2 = 64'(signed'(j_q.zq)) - 64'(newm_q);
    // both differences stay below 2^32 in magnitude
    m1 = d1[63] ? 32'(-d1) : 32'(d1);
    m2 = d2[63] ? 32'(-d2) : 32'(d2);
    mprod = 49'(signed'(c_q.mean)) * 49'(signed'({1'b0, c_q.cnt}));
    sm = 64'(mprod) + 64'(signed'(j_q.zq));
    vfull = 128'(ss_q) * 128'(c_q.cnt);
    sqt = sqr_q + sqb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0; nid_q <= '0; swc_q <= '0; ov_q <= 1'b0;
      mph_q <= '0; it_q <= '0;
    end else begin
      if (ov_q && pop_i) ov_q <= 1'b0;
      unique case (st_q)
        BkIdle: if (job_valid_i) begin
          j_q <= job_i;
          clr_q <= '0;
          if (job_i.act == ActSweep) swc_q <= swc_q + 32'd1;
          if (job_i.act == ActClear) begin nid_q <= '0; swc_q <= '0; end
        end
        BkClear: clr_q <= clr_q + 1'b1;
        BkRead: begin
          c_q <= rc; mph_q <= '0;
          n1_q <= 17'(rc.cnt) + 17'd1;
        end
        BkMul: begin
          // mean numerator magnitude, then square of std in later phase
          mph_q <= mph_q + 2'd1;
          if (mph_q == 2'd0) begin
            nsg_q <= sm[63];
            num_q <= {sm[63] ? 64'(-sm) : sm, 64'd0};
            rem_q <= '0; quo_q <= '0; it_q <= '0;
          end
          if (mph_q == 2'd1) ss_q <= 64'(c_q.sd) * 64'(c_q.sd);
        end
        BkDivM: begin
          it_q <= it_q + 7'd1;
          if (it_q == 7'd64) begin
            newm_q <= nsg_q ? -33'(quo_q[32:0]) : 33'(quo_q[32:0]);
            mph_q <= '0;
          end else begin
            num_q <= {num_q[126:0], 1'b0};
            if (rsh >= 19'(n1_q)) begin
              rem_q <= 18'(rsh - 19'(n1_q)); quo_q <= {quo_q[126:0], 1'b1};
            end else begin
              rem_q <= rsh[17:0]; quo_q <= {quo_q[126:0], 1'b0};
            end
          end
        end
        BkVar: begin
          mph_q <= mph_q + 2'd1;
          if (mph_q == 2'd0)
            prod_q <= 64'(m1) * 64'(m2);
          if (mph_q == 2'd2) begin
            if ((d1[63] != d2[63])) begin
              num_q <= (vfull < 128'(prod_q)) ? 128'd0 : vfull - 128'(prod_q);
            end else begin
              num_q <= vfull + 128'(prod_q);
            end
            rem_q <= '0; quo_q <= '0; it_q <= '0;
          end
          if (mph_q == 2'd3) c_q.sd <= '0;
        end
        BkDivV: begin
          num_q <= {num_q[126:0], 1'b0};
          if (rsh >= 19'(n1_q)) begin
            rem_q <= 18'(rsh - 19'(n1_q)); quo_q <= {quo_q[126:0], 1'b1};
          end else begin
            rem_q <= rsh[17:0]; quo_q <= {quo_q[126:0], 1'b0};
          end
          if (it_q == 7'd127) begin
            // quotient beyond 64 bits saturates
            sqv_q <= (quo_q[126:63] != 64'd0) ? '1 : {quo_q[62:0], rsh >= 19'(n1_q)};
            sqr_q <= '0; sqb_q <= 64'h4000_0000_0000_0000; it_q <= '0;
          end else begin
            it_q <= it_q + 7'd1;
          end
        end
        BkSqrt: begin
          // one result bit per cycle, 32 steps
          it_q <= it_q + 7'd1;
          if (it_q != 7'd32) begin
            if (sqv_q >= sqt) begin
              sqv_q <= sqv_q - sqt; sqr_q <= (sqr_q >> 1) + sqb_q;
            end else begin
              sqr_q <= sqr_q >> 1;
            end
            sqb_q <= sqb_q >> 2;
          end else begin
            c_q.sd <= sqr_q[31:0];
          end
        end
        default: ;
      endcase
      if (st_q == BkVar && mph_q == 2'd3) begin
        c_q.mean <= newm_q[31:0];
        if (c_q.cnt == 16'd0) begin
          c_q.id <= nid_q[15:0]; nid_q <= nid_q + 17'd1;
        end
        if (c_q.cnt != 16'hffff) c_q.cnt <= c_q.cnt + 16'd1;
        c_q.swp <= swc_q;
        if (signed'(j_q.px) < signed'(c_q.minx)) c_q.minx <= j_q.px;
        if (signed'(j_q.px) > signed'(c_q.maxx)) c_q.maxx <= j_q.px;
        if (signed'(j_q.py) < signed'(c_q.miny)) c_q.miny <= j_q.py;
        if (signed'(j_q.py) > signed'(c_q.maxy)) c_q.maxy <= j_q.py;
      end
      if (st_q == BkOut && !ov_q) begin
        ov_q <= 1'b1;
        om_q <= j_q.hit && c_q.cnt != 16'd0;
        oi_q <= (j_q.hit && c_q.cnt != 16'd0) ? 16'(j_q.cidx) : 16'd0;
      end
    end
  end

  assign empty_o      = !ov_q;
  assign in_map_o     = om_q;
  assign cell_index_o = oi_q;

  `GCPA_ASSERT(a_no_take_in_clear, clk_i, rst_ni, !(st_q == BkClear && job_ready_o))
  `GCPA_ASSERT(a_one_write, clk_i, rst_ni, !(mwe && job_ready_o))
  `GCPA_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, ov_q && !pop_i, ov_q && $stable(oi_q))
endmodule
